// ===== design/ecd_pkg.sv =====
package ecd_pkg;

  typedef logic signed [36:0] secs_t;
  typedef logic signed [13:0] year_t;
  typedef logic [3:0]         month_t;
  typedef logic [4:0]         mday_t;
  typedef logic [2:0]         wday_t;
  typedef logic [4:0]         hour_t;
  typedef logic [5:0]         sixty_t;
  typedef logic [20:0]        days_t;
  typedef logic [16:0]        tod_t;

  typedef struct packed {
    logic  valid;
    days_t days;
    tod_t  tod;
  } split_t;

  typedef struct packed {
    hour_t  hour;
    sixty_t minute;
    sixty_t second;
    wday_t  weekday;
  } hms_t;

  typedef struct packed {
    logic   valid;
    year_t  year;
    month_t month;
    mday_t  mday;
  } date_t;

  // whole number of days added so that the seconds count is never negative
  localparam logic [37:0] SECS_OFFSET = 38'd68719536000;
  // shifts the offset day count onto 0000-03-01 plus one era
  localparam logic [20:0] ZERO_SHIFT  = 21'd70200;

  localparam int unsigned SPLIT_STAGES = 3;
  localparam int unsigned TIME_STAGES  = 4;
  localparam int unsigned DATE_STAGES  = 14;
  localparam int unsigned LATENCY      = SPLIT_STAGES + DATE_STAGES;

  localparam logic [21:0] RCP_675   = 22'((64'd1 << 31) / 64'd675);
  localparam logic [11:0] RCP_60S   = 12'((64'd1 << 17) / 64'd60);
  localparam logic [5:0]  RCP_60M   = 6'((64'd1 << 11) / 64'd60);
  localparam logic [18:0] RCP_7     = 19'((64'd1 << 21) / 64'd7);
  localparam logic [3:0]  RCP_ERA   = 4'((64'd1 << 21) / 64'd146097);
  localparam logic [7:0]  RCP_1460  = 8'((64'd1 << 18) / 64'd1460);
  localparam logic [2:0]  RCP_36524 = 3'((64'd1 << 18) / 64'd36524);
  localparam logic [9:0]  RCP_365   = 10'((64'd1 << 18) / 64'd365);
  localparam logic [2:0]  RCP_100   = 3'((64'd1 << 9) / 64'd100);
  localparam logic [3:0]  RCP_153   = 4'((64'd1 << 11) / 64'd153);
  localparam logic [8:0]  RCP_5     = 9'((64'd1 << 11) / 64'd5);

endpackage

// ===== design/ecd_day_split.sv =====
module ecd_day_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           start_ok,
  input  ecd_pkg::secs_t secs,
  output ecd_pkg::split_t split
);
  import ecd_pkg::*;

  logic        v1, v2, v3;
  logic [37:0] u;
  logic [30:0] u7_2;
  logic [6:0]  lo_2;
  logic [20:0] q0_2;
  days_t       days_3;
  tod_t        tod_3;

  logic [52:0] prod;
  logic [30:0] r_full;
  logic [10:0] r;
  logic        ge;
  days_t       days_next;
  logic [9:0]  rem_next;

  always_comb begin
    prod      = 53'(u[37:7]) * 53'(RCP_675);
    r_full    = u7_2 - 31'(q0_2) * 31'd675;
    r         = r_full[10:0];
    ge        = r >= 11'd675;
    days_next = q0_2 + 21'(ge);
    rem_next  = ge ? 10'(r - 11'd675) : 10'(r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start_ok;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    u      <= {secs[36], secs} + SECS_OFFSET;
    u7_2   <= u[37:7];
    lo_2   <= u[6:0];
    q0_2   <= prod[51:31];
    days_3 <= days_next;
    tod_3  <= {rem_next, lo_2};
  end

  assign split = '{valid: v3, days: days_3, tod: tod_3};

endmodule

// ===== design/ecd_time_unit.sv =====
module ecd_time_unit (
  input  logic           clk,
  input  ecd_pkg::days_t days,
  input  ecd_pkg::tod_t  tod,
  output ecd_pkg::hms_t  hms
);
  import ecd_pkg::*;

  localparam int unsigned DLY = DATE_STAGES - TIME_STAGES;

  tod_t        tod1;
  logic [10:0] tq1;
  days_t       days1;
  logic [18:0] wq1;
  logic [10:0] mt2;
  sixty_t      sec2;
  wday_t       wd2;
  logic [10:0] mt3;
  logic [4:0]  hq3;
  sixty_t      sec3;
  wday_t       wd3;
  hms_t        core4;
  hms_t        line [DLY];

  logic [28:0] pt;
  logic [39:0] pw;
  logic [16:0] rt_full;
  logic [6:0]  rt;
  logic [20:0] rw_full;
  logic [3:0]  rw;
  logic [16:0] ph;
  logic [10:0] rh_full;
  logic [6:0]  rh;
  logic        ge_t, ge_h;
  hms_t        core_next;

  always_comb begin
    pt      = 29'(tod) * 29'(RCP_60S);
    pw      = 40'(days) * 40'(RCP_7);
    rt_full = tod1 - 17'(tq1) * 17'd60;
    rt      = rt_full[6:0];
    ge_t    = rt >= 7'd60;
    rw_full = days1 - 21'(wq1) * 21'd7;
    rw      = rw_full[3:0];
    ph      = 17'(mt2) * 17'(RCP_60M);
    rh_full = mt3 - 11'(hq3) * 11'd60;
    rh      = rh_full[6:0];
    ge_h    = rh >= 7'd60;
    core_next.hour    = hq3 + 5'(ge_h);
    core_next.minute  = ge_h ? 6'(rh - 7'd60) : 6'(rh);
    core_next.second  = sec3;
    core_next.weekday = wd3;
  end

  always_ff @(posedge clk) begin
    tod1  <= tod;
    tq1   <= pt[27:17];
    days1 <= days;
    wq1   <= pw[39:21];
    mt2   <= tq1 + 11'(ge_t);
    sec2  <= ge_t ? 6'(rt - 7'd60) : 6'(rt);
    wd2   <= (rw >= 4'd7) ? 3'(rw - 4'd7) : 3'(rw);
    mt3   <= mt2;
    hq3   <= ph[15:11];
    sec3  <= sec2;
    wd3   <= wd2;
    core4 <= core_next;
    line[0] <= core4;
    for (int i = 1; i < DLY; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign hms = line[DLY-1];

endmodule

// ===== design/ecd_date_unit.sv =====
module ecd_date_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  ecd_pkg::days_t days,
  output ecd_pkg::date_t date
);
  import ecd_pkg::*;

  logic [DATE_STAGES-1:0] vld;

  logic [20:0] z1;
  logic [3:0]  zq1;
  logic [3:0]  era2, era3, era4, era5, era6, era7, era8, era9, era10, era11, era12, era13;
  logic [17:0] doe2, doe3, doe4, doe5, doe6, doe7, doe8;
  logic [6:0]  qa3, a4;
  logic [2:0]  qb3, b4;
  logic        c3, c4;
  logic [17:0] t5, t6;
  logic [8:0]  tq6;
  logic [8:0]  yoe7, yoe8, yoe9, yoe10, yoe11, yoe12, yoe13;
  logic [1:0]  hq8;
  logic [17:0] k8;
  logic [8:0]  doy9, doy10, doy11, doy12, doy13;
  logic [10:0] n10, n2_12;
  logic [3:0]  mq10, mp11, mp12, mp13;
  logic [8:0]  dq12, dq13;
  year_t       year14;
  month_t      month14;
  mday_t       mday14;

  logic [20:0] z_next;
  logic [24:0] pz;
  logic [20:0] rz_full;
  logic [18:0] rz;
  logic        gez;
  logic [25:0] pa;
  logic [20:0] pb;
  logic [17:0] ra_full, rb_full;
  logic [11:0] ra;
  logic [16:0] rb;
  logic [27:0] pt;
  logic [17:0] ry_full;
  logic [9:0]  ry;
  logic [11:0] ph;
  logic [8:0]  rh_full;
  logic [7:0]  rh;
  logic [1:0]  h9;
  logic [17:0] doy_full;
  logic [10:0] n_next;
  logic [14:0] pm;
  logic [10:0] rm_full;
  logic [8:0]  rm;
  logic [10:0] n2_next;
  logic [19:0] pd;
  logic [10:0] rd_full;
  logic [3:0]  rd;
  logic [13:0] year_next;

  always_comb begin
    z_next   = days + ZERO_SHIFT;
    pz       = 25'(z_next) * 25'(RCP_ERA);
    rz_full  = z1 - 21'(zq1) * 21'd146097;
    rz       = rz_full[18:0];
    gez      = rz >= 19'd146097;
    pa       = 26'(doe2) * 26'(RCP_1460);
    pb       = 21'(doe2) * 21'(RCP_36524);
    ra_full  = doe3 - 18'(qa3) * 18'd1460;
    ra       = ra_full[11:0];
    rb_full  = doe3 - 18'(qb3) * 18'd36524;
    rb       = rb_full[16:0];
    pt       = 28'(t5) * 28'(RCP_365);
    ry_full  = t6 - 18'(tq6) * 18'd365;
    ry       = ry_full[9:0];
    ph       = 12'(yoe7) * 12'(RCP_100);
    rh_full  = yoe8 - 9'(hq8) * 9'd100;
    rh       = rh_full[7:0];
    h9       = hq8 + 2'(rh >= 8'd100);
    doy_full = doe8 - k8 + 18'(h9);
    n_next   = 11'(doy9) * 11'd5 + 11'd2;
    pm       = 15'(n_next) * 15'(RCP_153);
    rm_full  = n10 - 11'(mq10) * 11'd153;
    rm       = rm_full[8:0];
    n2_next  = 11'(mp11) * 11'd153 + 11'd2;
    pd       = 20'(n2_next) * 20'(RCP_5);
    rd_full  = n2_12 - 11'(dq12) * 11'd5;
    rd       = rd_full[3:0];
    year_next = 14'(yoe13) + 14'(era13) * 14'd400 - 14'd400 + 14'(mp13 >= 4'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DATE_STAGES-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    z1    <= z_next;
    zq1   <= pz[24:21];
    era2  <= zq1 + 4'(gez);
    doe2  <= gez ? 18'(rz - 19'd146097) : 18'(rz);
    qa3   <= pa[24:18];
    qb3   <= pb[20:18];
    c3    <= doe2 == 18'd146096;
    doe3  <= doe2;
    era3  <= era2;
    a4    <= qa3 + 7'(ra >= 12'd1460);
    b4    <= qb3 + 3'(rb >= 17'd36524);
    c4    <= c3;
    doe4  <= doe3;
    era4  <= era3;
    t5    <= doe4 - 18'(a4) + 18'(b4) - 18'(c4);
    doe5  <= doe4;
    era5  <= era4;
    tq6   <= pt[26:18];
    t6    <= t5;
    doe6  <= doe5;
    era6  <= era5;
    yoe7  <= tq6 + 9'(ry >= 10'd365);
    doe7  <= doe6;
    era7  <= era6;
    hq8   <= ph[10:9];
    k8    <= 18'(yoe7) * 18'd365 + 18'(yoe7[8:2]);
    yoe8  <= yoe7;
    doe8  <= doe7;
    era8  <= era7;
    doy9  <= doy_full[8:0];
    yoe9  <= yoe8;
    era9  <= era8;
    n10   <= n_next;
    mq10  <= pm[14:11];
    doy10 <= doy9;
    yoe10 <= yoe9;
    era10 <= era9;
    mp11  <= mq10 + 4'(rm >= 9'd153);
    doy11 <= doy10;
    yoe11 <= yoe10;
    era11 <= era10;
    n2_12 <= n2_next;
    dq12  <= pd[19:11];
    mp12  <= mp11;
    doy12 <= doy11;
    yoe12 <= yoe11;
    era12 <= era11;
    dq13  <= dq12 + 9'(rd >= 4'd5);
    mp13  <= mp12;
    doy13 <= doy12;
    yoe13 <= yoe12;
    era13 <= era12;
    mday14  <= 5'(doy13 - dq13 + 9'd1);
    month14 <= (mp13 < 4'd10) ? mp13 + 4'd3 : mp13 - 4'd9;
    year14  <= $signed(year_next);
  end

  assign date = '{valid: vld[DATE_STAGES-1], year: year14, month: month14, mday: mday14};

endmodule

// ===== design/epoch_seconds_to_civil_datetime.sv =====
// Epoch seconds to proleptic Gregorian date and time of day.
//
// Input: raise start with a signed 37-bit count of seconds since
// 1970-01-01 00:00:00 on epoch_seconds; the transaction is taken at the
// rising edge where start is high and busy is low. busy never rises, so a
// new transaction may be offered in every cycle.
// Output: done is high for exactly one cycle with year, month, day_of_month,
// weekday (0 = Sunday), hour, minute and second. The receiver cannot stall;
// each result is taken in the cycle it appears.
// Throughput one transaction per cycle. The delay from the accepting edge to
// done is set by the chain of constant-divisor steps on the date side, each
// a reciprocal multiply and a compare-and-subtract correction in stages of
// their own: three stages for days, two for the era, five for the year of
// era, two each for day of year, month and day, and one to form the outputs.
// Reset (synchronous, active high) drops every transaction in flight; no
// done follows a transaction accepted before reset.
module epoch_seconds_to_civil_datetime (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ecd_pkg::secs_t  epoch_seconds,
  output logic            busy,
  output logic            done,
  output ecd_pkg::year_t  year,
  output ecd_pkg::month_t month,
  output ecd_pkg::mday_t  day_of_month,
  output ecd_pkg::wday_t  weekday,
  output ecd_pkg::hour_t  hour,
  output ecd_pkg::sixty_t minute,
  output ecd_pkg::sixty_t second
);
  import ecd_pkg::*;

  split_t split;
  hms_t   hms;
  date_t  date;

  assign busy = 1'b0;

  ecd_day_split u_split (
    .clk      (clk),
    .rst      (rst),
    .start_ok (start & ~busy),
    .secs     (epoch_seconds),
    .split    (split)
  );

  ecd_time_unit u_time (
    .clk  (clk),
    .days (split.days),
    .tod  (split.tod),
    .hms  (hms)
  );

  ecd_date_unit u_date (
    .clk      (clk),
    .rst      (rst),
    .valid_in (split.valid),
    .days     (split.days),
    .date     (date)
  );

  assign done         = date.valid;
  assign year         = date.year;
  assign month        = date.month;
  assign day_of_month = date.mday;
  assign weekday      = hms.weekday;
  assign hour         = hms.hour;
  assign minute       = hms.minute;
  assign second       = hms.second;

endmodule

// ===== design/ecd_checker.sv =====
module ecd_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input ecd_pkg::month_t month,
  input ecd_pkg::mday_t  day_of_month,
  input ecd_pkg::wday_t  weekday,
  input ecd_pkg::hour_t  hour,
  input ecd_pkg::sixty_t minute,
  input ecd_pkg::sixty_t second
);
  import ecd_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction gave no result");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted transaction");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 &&
              weekday <= 3'd6 && hour <= 5'd23 && minute <= 6'd59 &&
              second <= 6'd59))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_civil_datetime ecd_checker u_checker (.*);

// ===== sim/tb_epoch_seconds_to_civil_datetime.sv =====
`default_nettype none

module tb_epoch_seconds_to_civil_datetime;
  timeunit 1ns;
  timeprecision 1ps;

  import ecd_pkg::*;

  localparam int RANDOM_STAMPS = 750;
  localparam int QUIET_TAIL    = 60;

  localparam longint CORNER_STAMPS [24] = '{
    0, -1, 1, 68719476735, -68719476736,
    86399, 86400, -86400, -86401,
    951782400, 951868800, 946684799, 946684800,
    -2203891201, -2203891200, 4107542399, 4107542400,
    -62162035201, -62162035200,
    2147483647, 2147483648, -2147483648, -2147483649,
    68719476735 - 86400
  };

  typedef struct packed {
    year_t  year;
    month_t month;
    mday_t  mday;
    wday_t  wday;
    hour_t  hour;
    sixty_t minute;
    sixty_t second;
  } civil_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  secs_t  epoch_seconds = '0;
  logic   busy;
  logic   done;
  year_t  year;
  month_t month;
  mday_t  day_of_month;
  wday_t  weekday;
  hour_t  hour;
  sixty_t minute;
  sixty_t second;

  secs_t  stamps_to_send [$];
  civil_t dates_due [$];
  int     gap = 0;
  bit     quiet = 1'b0;
  int     errors = 0;

  epoch_seconds_to_civil_datetime dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .epoch_seconds(epoch_seconds),
    .busy         (busy),
    .done         (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if (num % den != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic civil_t civil_of(secs_t stamp);
    longint secs, days, tod, z, era, doe, yoe, doy, mp, d, m, y, wd;
    civil_t c;
    secs = longint'(stamp);
    days = floor_quot(secs, 86400);
    tod  = secs - days * 86400;
    z    = days + 719468;
    era  = floor_quot(z, 146097);
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    d    = doy - (153 * mp + 2) / 5 + 1;
    m    = (mp < 10) ? mp + 3 : mp - 9;
    y    = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    wd   = (days + 4) % 7;
    if (wd < 0) wd += 7;
    c.year   = year_t'(y);
    c.month  = month_t'(m);
    c.mday   = mday_t'(d);
    c.wday   = wday_t'(wd);
    c.hour   = hour_t'(tod / 3600);
    c.minute = sixty_t'((tod / 60) % 60);
    c.second = sixty_t'(tod % 60);
    return c;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // driver: hold an offered transaction until taken, idle in bursts
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
    end else if (gap > 0) begin
      gap   <= gap - 1;
      start <= 1'b0;
    end else if (stamps_to_send.size() > 0) begin
      start         <= 1'b1;
      epoch_seconds <= stamps_to_send.pop_front();
      if ($urandom_range(0, 47) == 0) quiet <= !quiet;
      if (stamps_to_send.size() > QUIET_TAIL && !quiet && $urandom_range(0, 5) == 0)
        gap <= $urandom_range(1, 19);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: compare each result, then log the transaction taken at this edge
  always @(posedge clk) begin
    civil_t want;
    if (!rst) begin
      if (done) begin
        if (dates_due.size() == 0) begin
          $display("%0t ns: result with nothing outstanding, year %0d month %0d day %0d",
                   $time, year, month, day_of_month);
          errors++;
        end else begin
          want = dates_due.pop_front();
          check_field("year", longint'(want.year), longint'(year));
          check_field("month", longint'(want.month), longint'(month));
          check_field("day_of_month", longint'(want.mday), longint'(day_of_month));
          check_field("weekday", longint'(want.wday), longint'(weekday));
          check_field("hour", longint'(want.hour), longint'(hour));
          check_field("minute", longint'(want.minute), longint'(minute));
          check_field("second", longint'(want.second), longint'(second));
        end
      end
      if (start && !busy) dates_due.push_back(civil_of(epoch_seconds));
    end
  end

  initial begin
    longint t, days;
    foreach (CORNER_STAMPS[i]) stamps_to_send.push_back(secs_t'(CORNER_STAMPS[i]));
    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      case ($urandom_range(0, 3))
        0: t = longint'(secs_t'({5'($urandom_range(0, 31)), $urandom()}));
        1: begin
          days = longint'($urandom_range(0, 1590000)) - 795000;
          t = days * 86400 + longint'($urandom_range(0, 3)) - 2;
        end
        2: begin
          // land near the start of an era or of a century within it
          days = longint'($urandom_range(0, 9)) * 146097
               + longint'($urandom_range(0, 4)) * 36524
               + longint'($urandom_range(0, 4)) - 2 - 719468;
          t = days * 86400 + longint'($urandom_range(0, 86399));
        end
        default: t = longint'($urandom()) - 2147483648;
      endcase
      stamps_to_send.push_back(secs_t'(t));
    end

    @(negedge rst);
    while (stamps_to_send.size() != 0 || start || dates_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
